/* hw/rtl/cslru_pkg.sv */
package cslru_pkg;

    localparam int KEY_W   = 64;
    localparam int COST_W  = 32;
    localparam int CHUNK_W = 32;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 3;
    localparam int CNT_OUT_W = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;
    localparam int MAXTR_W = 7;
    localparam int FRAC_W  = 9;

    localparam logic [FRAC_W-1:0] FRAC_RESET = 9'd204;

    typedef enum logic [FUNC_W-1:0] {
        F_ACCESS = 2'd0,
        F_INSERT = 2'd1,
        F_REMOVE = 2'd2,
        F_EVICT  = 2'd3
    } t_func;

    localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STAT_W-1:0] ST_MISS    = 3'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd3;
    localparam logic [STAT_W-1:0] ST_EVICTED = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXTR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAC   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_UPD,
        S_DONE
    } t_state;

endpackage

/* hw/rtl/cslru_mem.sv */
module cslru_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 136
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/cost_weighted_slru_eviction_top.sv */
// Segmented LRU tracker with cost-weighted eviction. A command is taken when
// start is high and busy is low; its one result appears on the o_ ports for a
// single cycle with o_valid, and must be captured then. Every entry lives in
// one single-port-read, single-port-write memory and each command walks it
// one slot per cycle: a search pass (one read per slot, then the read latency
// and a step to settle the decision), then, for commands that change the
// table, a read-modify-write pass over every slot, plus an idle state to
// accept the command and a done state to present the result. A miss, a full
// table or an empty evict skips the read-modify-write pass.
// After reset the block clears the memory with busy held high.
// Configuration beats are always accepted and are meant to be written only
// while busy is low.
module cost_weighted_slru_eviction_top #(
    parameter int CAPACITY    = 64,
    parameter int SCAN_WINDOW = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [cslru_pkg::FUNC_W-1:0]        i_func,
    input  logic [cslru_pkg::KEY_W-1:0]         i_key,
    input  logic [cslru_pkg::COST_W-1:0]        i_cost,
    input  logic [cslru_pkg::CHUNK_W-1:0]       i_chunk_index,
    output logic                                o_valid,
    output logic [cslru_pkg::STAT_W-1:0]        o_status,
    output logic [cslru_pkg::KEY_W-1:0]         o_victim_key,
    output logic [cslru_pkg::CNT_OUT_W-1:0]     o_protected_count,
    output logic [cslru_pkg::CNT_OUT_W-1:0]     o_probationary_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cslru_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cslru_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    import cslru_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int RW = AW;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int BW = (CW > MAXTR_W) ? CW : MAXTR_W;
    localparam int LW = BW + 2;
    localparam int PW = BW + FRAC_W;
    localparam int EW = 2 + RW + KEY_W + COST_W + CHUNK_W;

    // Configuration registers.
    logic [COST_W-1:0]  r_thr;
    logic [MAXTR_W-1:0] r_maxtr;
    logic [FRAC_W-1:0]  r_frac;

    t_state r_state, n_state;
    logic [AW:0]   r_cnt;
    logic          r_pv;
    logic [AW-1:0] r_pidx;
    logic          scan_issue, pass_end;

    t_func              r_func;
    logic [KEY_W-1:0]   r_key;
    logic [COST_W-1:0]  r_cost;
    logic [CHUNK_W-1:0] r_chunk;

    // Search results.
    logic               r_found, r_sprot;
    logic [AW-1:0]      r_s;
    logic [RW-1:0]      r_srank;
    logic               r_ffound;
    logic [AW-1:0]      r_free;
    logic               r_bfound;
    logic [AW-1:0]      r_bslot;
    logic [CHUNK_W-1:0] r_bchunk;
    logic [COST_W-1:0]  r_bcost;
    logic [RW-1:0]      r_brank;
    logic [KEY_W-1:0]   r_bkey;

    logic [CW-1:0] r_pt, r_pb;
    logic [BW:0]   r_limit;

    // Controls of the update pass.
    logic [AW-1:0] r_tgt;
    logic          r_unl, r_push, r_P, r_Q, r_newrec, r_setcost;
    logic [RW-1:0] r_R;
    logic [CW-1:0] r_k, r_dbase;

    logic [STAT_W-1:0] r_status;
    logic [KEY_W-1:0]  r_victim;

    // Memory port.
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata, mem_rdata;

    cslru_mem #(
        .DEPTH(CAPACITY),
        .WIDTH(EW)
    ) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(r_cnt[AW-1:0]),
        .o_rdata(mem_rdata)
    );

    logic               e_v, e_p;
    logic [RW-1:0]      e_r;
    logic [KEY_W-1:0]   e_key;
    logic [COST_W-1:0]  e_cost;
    logic [CHUNK_W-1:0] e_chunk;

    assign {e_v, e_p, e_r, e_key, e_cost, e_chunk} = mem_rdata;

    assign scan_issue = (r_cnt < (AW+1)'(CAPACITY));
    assign pass_end   = !scan_issue && !r_pv;

    // Eviction source segment and window test.
    logic          eseg_prot;
    logic [CW-1:0] eseg_n;
    logic          in_window, better;

    assign eseg_prot = (r_pb == '0);
    assign eseg_n    = eseg_prot ? r_pt : r_pb;
    assign in_window = (LW'(e_r) + LW'(SCAN_WINDOW)) >= LW'(eseg_n);
    assign better    = !r_bfound || (e_chunk > r_bchunk) ||
                       ((e_chunk == r_bchunk) && (e_cost < r_bcost)) ||
                       ((e_chunk == r_bchunk) && (e_cost == r_bcost) && (e_r > r_brank));

    // Protected limit, registered after the multiply.
    logic [BW-1:0] basis;
    logic [PW-1:0] prod;

    assign basis = (r_maxtr != '0) ? BW'(r_maxtr) : (BW'(r_pt) + BW'(r_pb));
    assign prod  = PW'(basis) * PW'(r_frac);

    // Decision at the end of the search pass.
    logic              d_upd, d_unl, d_push, d_P, d_Q, d_newrec, d_setcost;
    logic [AW-1:0]     d_tgt;
    logic [RW-1:0]     d_R;
    logic [CW-1:0]     d_k, d_dbase, d_pt, d_pb;
    logic [STAT_W-1:0] d_status;
    logic [KEY_W-1:0]  d_victim;
    logic [LW-1:0]     pt_after, lim_ext, dbase_l, k_l;

    always_comb begin
        pt_after = LW'(r_pt) + LW'(1);
        lim_ext  = LW'(r_limit);
        dbase_l  = (pt_after > lim_ext) ? lim_ext : pt_after;
        k_l      = pt_after - dbase_l;

        d_upd     = 1'b0;
        d_unl     = 1'b0;
        d_push    = 1'b0;
        d_P       = r_sprot;
        d_Q       = r_sprot;
        d_R       = r_srank;
        d_tgt     = r_s;
        d_newrec  = 1'b0;
        d_setcost = 1'b0;
        d_k       = '0;
        d_dbase   = '0;
        d_pt      = r_pt;
        d_pb      = r_pb;
        d_status  = ST_DONE;
        d_victim  = '0;
        case (r_func)
            F_ACCESS: begin
                if (!r_found) begin
                    d_status = ST_MISS;
                end else begin
                    d_upd     = 1'b1;
                    d_unl     = 1'b1;
                    d_push    = 1'b1;
                    d_setcost = 1'b1;
                    if (!r_sprot && (r_cost >= r_thr)) begin
                        // Promotion, then protected overflow goes back in one pass.
                        d_Q     = 1'b1;
                        d_k     = CW'(k_l);
                        d_dbase = CW'(dbase_l);
                        d_pt    = CW'(dbase_l);
                        d_pb    = r_pb - CW'(1) + CW'(k_l);
                    end
                end
            end
            F_INSERT: begin
                if (r_found) begin
                    d_upd     = 1'b1;
                    d_unl     = 1'b1;
                    d_push    = 1'b1;
                    d_setcost = 1'b1;
                end else if (((LW'(r_pt) + LW'(r_pb)) >= LW'(CAPACITY)) || !r_ffound) begin
                    d_status = ST_FULL;
                end else begin
                    d_upd     = 1'b1;
                    d_tgt     = r_free;
                    d_push    = 1'b1;
                    d_Q       = 1'b0;
                    d_newrec  = 1'b1;
                    d_setcost = 1'b1;
                    d_pb      = r_pb + CW'(1);
                end
            end
            F_REMOVE: begin
                if (!r_found) begin
                    d_status = ST_MISS;
                end else begin
                    d_upd = 1'b1;
                    d_unl = 1'b1;
                    if (r_sprot) begin
                        d_pt = r_pt - CW'(1);
                    end else begin
                        d_pb = r_pb - CW'(1);
                    end
                end
            end
            F_EVICT: begin
                if (!r_bfound) begin
                    d_status = ST_EMPTY;
                end else begin
                    d_upd    = 1'b1;
                    d_unl    = 1'b1;
                    d_tgt    = r_bslot;
                    d_P      = eseg_prot;
                    d_R      = r_brank;
                    d_status = ST_EVICTED;
                    d_victim = r_bkey;
                    if (eseg_prot) begin
                        d_pt = r_pt - CW'(1);
                    end else begin
                        d_pb = r_pb - CW'(1);
                    end
                end
            end
            default: begin
                d_status = ST_DONE;
            end
        endcase
    end

    // Per-entry rewrite during the update pass.
    logic               w_v, w_p;
    logic [RW-1:0]      w_r;
    logic [KEY_W-1:0]   w_key;
    logic [COST_W-1:0]  w_cost;
    logic [CHUNK_W-1:0] w_chunk;

    always_comb begin
        w_v     = e_v;
        w_p     = e_p;
        w_r     = e_r;
        w_key   = e_key;
        w_cost  = e_cost;
        w_chunk = e_chunk;
        if (r_pidx == r_tgt) begin
            if (r_push) begin
                w_v = 1'b1;
                w_p = r_Q;
                w_r = '0;
                if (r_setcost) begin
                    w_cost = r_cost;
                end
                if (r_newrec) begin
                    w_key   = r_key;
                    w_chunk = r_chunk;
                end
            end else begin
                w_v = 1'b0;
            end
        end else if (e_v) begin
            if (r_unl && (e_p == r_P) && (e_r > r_R)) begin
                w_r = w_r - RW'(1);
            end
            if (r_push && (e_p == r_Q)) begin
                w_r = w_r + RW'(1);
            end
        end
        // The k least recent protected entries move, in order, to the probationary MRU end.
        if (w_v && (r_k != '0)) begin
            if (!w_p) begin
                w_r = w_r + RW'(r_k);
            end else if (CW'(w_r) >= r_dbase) begin
                w_p = 1'b0;
                w_r = RW'(CW'(w_r) - r_dbase);
            end
        end
    end

    assign mem_we    = ((r_state == S_CLEAR) && scan_issue) || ((r_state == S_UPD) && r_pv);
    assign mem_waddr = (r_state == S_CLEAR) ? r_cnt[AW-1:0] : r_pidx;
    assign mem_wdata = (r_state == S_CLEAR) ? '0 :
                       {w_v, w_p, w_r, w_key, w_cost, w_chunk};

    // State machine.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (!scan_issue) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_FIND;
                end
            end
            S_FIND: begin
                if (pass_end) begin
                    n_state = d_upd ? S_UPD : S_DONE;
                end
            end
            S_UPD: begin
                if (pass_end) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_pv    <= 1'b0;
            r_pt    <= '0;
            r_pb    <= '0;
            r_thr   <= '0;
            r_maxtr <= '0;
            r_frac  <= FRAC_RESET;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_THRESH: r_thr   <= i_cfg_data;
                    CFG_MAXTR:  r_maxtr <= i_cfg_data[MAXTR_W-1:0];
                    CFG_FRAC:   r_frac  <= i_cfg_data[FRAC_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_pv <= ((r_state == S_FIND) || (r_state == S_UPD)) && scan_issue;
            if ((r_state == S_IDLE) || ((r_state == S_FIND) && pass_end)) begin
                r_cnt <= '0;
            end else if (scan_issue) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end
            if ((r_state == S_FIND) && pass_end) begin
                r_pt <= d_pt;
                r_pb <= d_pb;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_pidx  <= r_cnt[AW-1:0];
        r_limit <= prod[PW-1:FRAC_W-1];
        if ((r_state == S_IDLE) && start) begin
            r_func   <= t_func'(i_func);
            r_key    <= i_key;
            r_cost   <= i_cost;
            r_chunk  <= i_chunk_index;
            r_found  <= 1'b0;
            r_ffound <= 1'b0;
            r_bfound <= 1'b0;
        end
        if ((r_state == S_FIND) && r_pv) begin
            if (e_v && (e_key == r_key) && !r_found) begin
                r_found <= 1'b1;
                r_s     <= r_pidx;
                r_sprot <= e_p;
                r_srank <= e_r;
            end
            if (!e_v && !r_ffound) begin
                r_ffound <= 1'b1;
                r_free   <= r_pidx;
            end
            if (e_v && (e_p == eseg_prot) && in_window && better) begin
                r_bfound <= 1'b1;
                r_bslot  <= r_pidx;
                r_bchunk <= e_chunk;
                r_bcost  <= e_cost;
                r_brank  <= e_r;
                r_bkey   <= e_key;
            end
        end
        if ((r_state == S_FIND) && pass_end) begin
            r_tgt     <= d_tgt;
            r_unl     <= d_unl;
            r_push    <= d_push;
            r_P       <= d_P;
            r_Q       <= d_Q;
            r_R       <= d_R;
            r_newrec  <= d_newrec;
            r_setcost <= d_setcost;
            r_k       <= d_k;
            r_dbase   <= d_dbase;
            r_status  <= d_status;
            r_victim  <= d_victim;
        end
    end

    assign busy                 = (r_state != S_IDLE);
    assign o_valid              = (r_state == S_DONE);
    assign o_status             = r_status;
    assign o_victim_key         = r_victim;
    assign o_protected_count    = CNT_OUT_W'(r_pt);
    assign o_probationary_count = CNT_OUT_W'(r_pb);
    assign o_cfg_ready          = 1'b1;

`ifndef SYNTHESIS
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held longer than one cycle");
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted without going busy");
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (LW'(r_pt) + LW'(r_pb)) <= LW'(CAPACITY))
        else $error("segment counts exceed capacity");
    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != ST_EVICTED)) |-> (o_victim_key == '0))
        else $error("victim key set without an eviction");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("memory written while idle");
`endif

endmodule
